/* rtl/krt_pkg.sv */
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants of the keyed record table.
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

  localparam int CAPACITY    = 64;
  localparam int MAX_RESULTS = 64;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int LIM_CAP     = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

  localparam int KEY_W   = 24;
  localparam int PRICE_W = 20;

  // request kinds
  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_SEARCH = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_COUNT  = 3'd3;
  localparam logic [2:0] KIND_LIST   = 3'd4;
  localparam logic [2:0] KIND_SORTED = 3'd5;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic               issued;
    logic [PRICE_W-1:0] price;
    logic [KEY_W-1:0]   key;
  } rec_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] ord;
  } srt_t;

endpackage

`default_nettype wire

/* rtl/keyed_record_table_unit.sv */
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// Record table with linear search, shifting delete and exchange-sorted listing.
// ----------------------------------------------------------------------------
// search makes a counting pass, then a reporting pass; delete scans for the key, then
// moves the following records down; sorted listing copies the keys into the sort
// memory (one write and one read port) and exchange-sorts them there before listing
// one request at a time; the next beat is taken once all results are queued
// reset: synchronous, active low; clears the entry count and control state,
// the record memories hold no reset value
`default_nettype none

module keyed_record_table_unit
  import krt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // key[23:0], price_cents[43:24], issued[44]
  input  wire logic [2:0]  in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata,  // slot, record_key, record_price, record_issued,
                                       // entry_total
  output logic      [1:0]  out_tuser,  // status
  output logic             out_tlast
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ONE   = 5'd1;
  localparam logic [4:0] S_SR_RD = 5'd2;
  localparam logic [4:0] S_SR_CK = 5'd3;
  localparam logic [4:0] S_SE_RD = 5'd4;
  localparam logic [4:0] S_SE_CK = 5'd5;
  localparam logic [4:0] S_DL_RD = 5'd6;
  localparam logic [4:0] S_DL_CK = 5'd7;
  localparam logic [4:0] S_SH_RD = 5'd8;
  localparam logic [4:0] S_SH_WR = 5'd9;
  localparam logic [4:0] S_LS_RD = 5'd10;
  localparam logic [4:0] S_LS_EM = 5'd11;
  localparam logic [4:0] S_CP_RD = 5'd12;
  localparam logic [4:0] S_CP_WR = 5'd13;
  localparam logic [4:0] S_SO_RD = 5'd14;
  localparam logic [4:0] S_SO_CK = 5'd15;
  localparam logic [4:0] S_SO_WB = 5'd16;
  localparam logic [4:0] S_LO_RD = 5'd17;
  localparam logic [4:0] S_LO_RR = 5'd18;
  localparam logic [4:0] S_LO_RW = 5'd19;
  localparam logic [4:0] S_LO_EM = 5'd20;

  logic [4:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]   ord_r, ord_nxt;
  logic [CNT_W-1:0]   nm_r, nm_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]   lim_r, lim_nxt;
  logic               first_r, first_nxt;
  logic [KEY_W-1:0]   key_q_r, key_q_nxt;
  srt_t               held_r, held_nxt;
  logic [1:0]         res_st_r, res_st_nxt;
  logic [IDX_W-1:0]   res_slot_r, res_slot_nxt;
  rec_t               res_rec_r, res_rec_nxt;

  logic               out_valid_r;
  logic [63:0]        out_data_r;
  logic [1:0]         out_st_r;
  logic               out_last_r;

  logic               ld;
  logic [1:0]         ld_st;
  logic [IDX_W-1:0]   ld_slot;
  rec_t               ld_rec;
  logic               ld_last;

  logic               rec_we, srt_we;
  logic [IDX_W-1:0]   rec_waddr, rec_raddr, srt_waddr, srt_raddr;
  rec_t               rec_wdata, rec_rdata;
  srt_t               srt_wdata, srt_rdata;

  logic               acc, ofree, at_end, hit;
  logic [CNT_W-1:0]   lim_cnt, nm_inc;
  rec_t               in_rec;

  krt_ram #(.WIDTH($bits(rec_t)), .DEPTH(CAPACITY)) u_rec_ram (
    .clk  (clk),
    .we   (rec_we),
    .waddr(rec_waddr),
    .wdata(rec_wdata),
    .raddr(rec_raddr),
    .rdata(rec_rdata)
  );

  krt_ram #(.WIDTH($bits(srt_t)), .DEPTH(CAPACITY)) u_srt_ram (
    .clk  (clk),
    .we   (srt_we),
    .waddr(srt_waddr),
    .wdata(srt_wdata),
    .raddr(srt_raddr),
    .rdata(srt_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign acc        = in_tvalid && in_tready;
  assign ofree      = !out_valid_r || out_tready;
  assign at_end     = ({{(CNT_W-IDX_W){1'b0}}, idx_r} == cnt_r - CNT_W'(1));
  assign hit        = (rec_rdata.key == key_q_r);
  assign lim_cnt    = (cnt_r > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : cnt_r;
  assign nm_inc     = nm_r + CNT_W'(hit);
  assign in_rec     = '{issued: in_tdata[44], price: in_tdata[43:24], key: in_tdata[23:0]};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  // memory addressing by phase
  always_comb begin
    rec_raddr = idx_r;
    srt_raddr = idx_r;
    if (state_r == S_SH_RD || state_r == S_SH_WR) begin
      rec_raddr = idx_r + IDX_W'(1);
    end else if (state_r == S_LO_RW || state_r == S_LO_EM) begin
      rec_raddr = ord_r;
    end
    if (state_r == S_SO_RD || state_r == S_SO_CK) begin
      srt_raddr = j_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    j_nxt        = j_r;
    ord_nxt      = ord_r;
    nm_nxt       = nm_r;
    k_nxt        = k_r;
    lim_nxt      = lim_r;
    first_nxt    = first_r;
    key_q_nxt    = key_q_r;
    held_nxt     = held_r;
    res_st_nxt   = res_st_r;
    res_slot_nxt = res_slot_r;
    res_rec_nxt  = res_rec_r;
    rec_we       = 1'b0;
    rec_waddr    = idx_r;
    rec_wdata    = rec_rdata;
    srt_we       = 1'b0;
    srt_waddr    = idx_r;
    srt_wdata    = '{key: rec_rdata.key, ord: idx_r};
    ld           = 1'b0;
    ld_st        = ST_OK;
    ld_slot      = idx_r;
    ld_rec       = rec_rdata;
    ld_last      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          key_q_nxt    = in_tdata[23:0];
          idx_nxt      = '0;
          nm_nxt       = '0;
          k_nxt        = '0;
          lim_nxt      = lim_cnt;
          res_st_nxt   = ST_OK;
          res_slot_nxt = '0;
          res_rec_nxt  = '0;
          unique case (in_tuser)
            KIND_ADD: begin
              state_nxt = S_ONE;
              if (cnt_r >= CNT_W'(CAPACITY)) begin
                res_st_nxt = ST_FULL;
              end else begin
                rec_we       = 1'b1;
                rec_waddr    = cnt_r[IDX_W-1:0];
                rec_wdata    = in_rec;
                cnt_nxt      = cnt_r + CNT_W'(1);
                res_slot_nxt = cnt_r[IDX_W-1:0];
                res_rec_nxt  = in_rec;
              end
            end
            KIND_SEARCH, KIND_DELETE: begin
              if (cnt_r == '0) begin
                res_st_nxt = ST_NOTFOUND;
                state_nxt  = S_ONE;
              end else begin
                state_nxt = (in_tuser == KIND_SEARCH) ? S_SR_RD : S_DL_RD;
              end
            end
            KIND_COUNT: begin
              state_nxt = S_ONE;
            end
            KIND_LIST, KIND_SORTED: begin
              if (cnt_r == '0) begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_ONE;
              end else begin
                state_nxt = (in_tuser == KIND_LIST) ? S_LS_RD : S_CP_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ONE: begin
        if (ofree) begin
          ld        = 1'b1;
          ld_st     = res_st_r;
          ld_slot   = res_slot_r;
          ld_rec    = res_rec_r;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // search, counting pass
      S_SR_RD: state_nxt = S_SR_CK;
      S_SR_CK: begin
        nm_nxt = nm_inc;
        if (at_end) begin
          idx_nxt = '0;
          if (nm_inc == '0) begin
            res_st_nxt = ST_NOTFOUND;
            state_nxt  = S_ONE;
          end else begin
            lim_nxt   = (nm_inc > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : nm_inc;
            state_nxt = S_SE_RD;
          end
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SR_RD;
        end
      end
      // search, reporting pass
      S_SE_RD: state_nxt = S_SE_CK;
      S_SE_CK: begin
        if (!hit) begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SE_RD;
        end else if (ofree) begin
          ld      = 1'b1;
          ld_last = (k_r + CNT_W'(1) == lim_r);
          k_nxt   = k_r + CNT_W'(1);
          idx_nxt = idx_r + IDX_W'(1);
          state_nxt = ld_last ? S_IDLE : S_SE_RD;
        end
      end
      S_DL_RD: state_nxt = S_DL_CK;
      S_DL_CK: begin
        if (hit) begin
          res_slot_nxt = idx_r;
          res_rec_nxt  = rec_rdata;
          if (at_end) begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = S_ONE;
          end else begin
            state_nxt = S_SH_RD;
          end
        end else if (at_end) begin
          res_st_nxt = ST_NOTFOUND;
          state_nxt  = S_ONE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_DL_RD;
        end
      end
      // move the following records down one slot
      S_SH_RD: state_nxt = S_SH_WR;
      S_SH_WR: begin
        rec_we = 1'b1;
        if ({{(CNT_W-IDX_W){1'b0}}, idx_r} + CNT_W'(2) == cnt_r) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_ONE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SH_RD;
        end
      end
      S_LS_RD: state_nxt = S_LS_EM;
      S_LS_EM: begin
        if (ofree) begin
          ld      = 1'b1;
          ld_last = ({{(CNT_W-IDX_W){1'b0}}, idx_r} + CNT_W'(1) == lim_r);
          idx_nxt = idx_r + IDX_W'(1);
          state_nxt = ld_last ? S_IDLE : S_LS_RD;
        end
      end
      // copy keys and slot numbers into the sort memory
      S_CP_RD: state_nxt = S_CP_WR;
      S_CP_WR: begin
        srt_we = 1'b1;
        if (at_end) begin
          idx_nxt   = '0;
          j_nxt     = '0;
          first_nxt = 1'b1;
          state_nxt = S_SO_RD;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_CP_RD;
        end
      end
      // exchange sort: entry i lives in held_r while j sweeps
      S_SO_RD: state_nxt = S_SO_CK;
      S_SO_CK: begin
        if (first_r) begin
          held_nxt  = srt_rdata;
          first_nxt = 1'b0;
        end else if (held_r.key > srt_rdata.key) begin
          srt_we    = 1'b1;
          srt_waddr = j_r;
          srt_wdata = held_r;
          held_nxt  = srt_rdata;
        end
        if ({{(CNT_W-IDX_W){1'b0}}, j_r} == cnt_r - CNT_W'(1)) begin
          state_nxt = S_SO_WB;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_SO_RD;
        end
      end
      S_SO_WB: begin
        srt_we    = 1'b1;
        srt_wdata = held_r;
        if (at_end) begin
          idx_nxt   = '0;
          state_nxt = S_LO_RD;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          j_nxt     = idx_r + IDX_W'(1);
          first_nxt = 1'b1;
          state_nxt = S_SO_RD;
        end
      end
      S_LO_RD: state_nxt = S_LO_RR;
      S_LO_RR: begin
        ord_nxt   = srt_rdata.ord;
        state_nxt = S_LO_RW;
      end
      S_LO_RW: state_nxt = S_LO_EM;
      S_LO_EM: begin
        if (ofree) begin
          ld      = 1'b1;
          ld_slot = ord_r;
          ld_last = ({{(CNT_W-IDX_W){1'b0}}, idx_r} + CNT_W'(1) == lim_r);
          idx_nxt = idx_r + IDX_W'(1);
          state_nxt = ld_last ? S_IDLE : S_LO_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    j_r        <= j_nxt;
    ord_r      <= ord_nxt;
    nm_r       <= nm_nxt;
    k_r        <= k_nxt;
    lim_r      <= lim_nxt;
    first_r    <= first_nxt;
    key_q_r    <= key_q_nxt;
    held_r     <= held_nxt;
    res_st_r   <= res_st_nxt;
    res_slot_r <= res_slot_nxt;
    res_rec_r  <= res_rec_nxt;
    if (ld) begin
      // entry_total is taken after the count update of this request
      out_data_r <= {6'd0, 7'(cnt_nxt), ld_rec.issued, ld_rec.price, ld_rec.key,
                     6'(ld_slot)};
      out_st_r   <= ld_st;
      out_last_r <= ld_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/krt_ram.sv */
// ----------------------------------------------------------------------------
// krt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
